// ===== hw/rtl/ipbf_pkg.sv =====
// shared types and constants for the ip and port ban filter
package ipbf_pkg;

  // protocol numbers that carry a destination port
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // field widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned PROTO_W = 8;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned COUNT_W = 7;

  // stream widths, fields packed from the lowest bit up and padded to bytes
  localparam int unsigned IN_BITS   = CMD_W + IP_W + PROTO_W + PORT_W + IP_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = 1 + 1 + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLASSIFY = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_ADD_IP   = 3'd2,
    CMD_ADD_PORT = 3'd3,
    CMD_DEL_IP   = 3'd4,
    CMD_DEL_PORT = 3'd5
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT,
    ST_CLEAR,
    ST_RESP
  } state_t;

  // one rule table word
  typedef struct packed {
    logic            valid;
    logic            is_port;
    logic [IP_W-1:0] value;
  } rule_entry_t;

  // search key presented to the compare unit
  typedef struct packed {
    logic              any_kind;
    logic              is_port;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } rule_key_t;

  // per-entry result of the compare unit
  typedef struct packed {
    logic hit;
    logic free;
  } scan_res_t;

endpackage

// ===== hw/rtl/ip_port_ban_filter_unit.sv =====
// top level of the ip and port ban filter: sequencer, command registers, stream ports
//
// Keeps up to MAX_RULES ban rules (source address or destination port) in a
// single-port-write, single-port-read table and answers one command per
// input transfer with one result transfer. Classify, add and remove walk the
// whole table through one compare unit, one entry per cycle, then pass a tail
// state, and add a commit state, before the result. Clear writes every entry
// invalid. Unknown commands go from idle straight to the result. After reset
// the table is swept invalid before the first input transfer is taken. One
// command is in work at a time; in_tready is high only while the block is
// idle and no result is waiting.
module ip_port_ban_filter_unit #(
  parameter int unsigned MAX_RULES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd[2:0], src_ip[34:3], protocol[42:35], dst_port[58:43], rule_value[90:59]
  input  logic [ipbf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // drop[0], status[1], rule_count[8:2]
  output logic [ipbf_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ipbf_pkg::*;

  localparam int unsigned AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW = $clog2(MAX_RULES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_RULES - 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [IP_W-1:0]     ip_r;
  logic [PROTO_W-1:0]  proto_r;
  logic [PORT_W-1:0]   hport_r;
  logic [IP_W-1:0]     rv_r;
  logic                drop_r, drop_nxt;
  logic                status_r, status_nxt;
  logic                found_r, found_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;

  logic                rd_en;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  rule_entry_t         wr_entry;
  rule_key_t           key;
  scan_res_t           res;
  logic [AW-1:0]       res_addr;
  logic                last_idx;
  logic                is_del;
  logic                is_add;
  logic                cmd_port;
  logic [CW+COUNT_W-1:0] count_ext;

  assign last_idx = (idx_r == LAST_IDX);
  assign is_del   = (cmd_r == CMD_DEL_IP) || (cmd_r == CMD_DEL_PORT);
  assign is_add   = (cmd_r == CMD_ADD_IP) || (cmd_r == CMD_ADD_PORT);
  assign cmd_port = (cmd_r == CMD_ADD_PORT) || (cmd_r == CMD_DEL_PORT);

  // search key from the captured command
  always_comb begin
    key.any_kind = (cmd_r == CMD_CLASSIFY);
    key.is_port  = cmd_port;
    if (cmd_r == CMD_CLASSIFY) begin
      key.ip   = ip_r;
      key.port = ((proto_r == PROTO_TCP) || (proto_r == PROTO_UDP)) ? hport_r
                                                                    : '0;
    end else begin
      key.ip   = rv_r;
      key.port = rv_r[PORT_W-1:0];
    end
  end

  ipbf_rule_table #(
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (idx_r),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .key      (key),
    .res      (res),
    .res_addr (res_addr)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (last_idx) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tdata[CMD_W-1:0]) inside
            CMD_CLASSIFY, CMD_ADD_IP, CMD_ADD_PORT,
            CMD_DEL_IP, CMD_DEL_PORT: state_nxt = ST_SCAN;
            CMD_CLEAR:                state_nxt = ST_CLEAR;
            default:                  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (last_idx) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        state_nxt = is_add ? ST_COMMIT : ST_RESP;
      end
      ST_COMMIT: begin
        state_nxt = ST_RESP;
      end
      ST_CLEAR: begin
        if (last_idx) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // state outputs: handshake, table ports
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_RESP);
    rd_en      = (state_r == ST_SCAN);
    wr_en      = 1'b0;
    wr_addr    = idx_r;
    wr_entry   = '{valid: 1'b0, is_port: 1'b0, value: '0};
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_COMMIT: begin
        wr_en    = found_r;
        wr_addr  = free_idx_r;
        wr_entry = '{valid: 1'b1, is_port: cmd_port,
                     value: cmd_port ? {{(IP_W-PORT_W){1'b0}}, rv_r[PORT_W-1:0]} : rv_r};
      end
      default: begin
        // removal clears a matching entry as its read result comes back
        if (is_del && res.hit) begin
          wr_en   = 1'b1;
          wr_addr = res_addr;
        end
      end
    endcase
  end

  // datapath next values
  always_comb begin
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    status_nxt   = status_r;
    found_nxt    = found_r;
    free_idx_nxt = free_idx_r;
    if ((state_r == ST_INIT) || (state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
      idx_nxt = last_idx ? '0 : idx_r + 1'b1;
    end
    if (state_r == ST_IDLE && in_tvalid) begin
      drop_nxt   = 1'b0;
      status_nxt = 1'b0;
      found_nxt  = 1'b0;
    end
    // scan results
    if ((state_r == ST_SCAN) || (state_r == ST_TAIL)) begin
      if ((cmd_r == CMD_CLASSIFY) && res.hit) drop_nxt = 1'b1;
      if (is_del && res.hit) count_nxt = count_r - 1'b1;
      if (is_add && res.free && !found_r) begin
        found_nxt    = 1'b1;
        free_idx_nxt = res_addr;
      end
    end
    if (state_r == ST_COMMIT) begin
      if (found_r) count_nxt = count_r + 1'b1;
      status_nxt = !found_r;
    end
    if (state_r == ST_CLEAR) begin
      count_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      idx_r    <= '0;
      count_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      count_r  <= count_nxt;
      found_r  <= found_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    drop_r     <= drop_nxt;
    status_r   <= status_nxt;
    free_idx_r <= free_idx_nxt;
    if (state_r == ST_IDLE && in_tvalid) begin
      cmd_r   <= in_tdata[CMD_W-1:0];
      ip_r    <= in_tdata[CMD_W +: IP_W];
      proto_r <= in_tdata[CMD_W+IP_W +: PROTO_W];
      hport_r <= in_tdata[CMD_W+IP_W+PROTO_W +: PORT_W];
      rv_r    <= in_tdata[CMD_W+IP_W+PROTO_W+PORT_W +: IP_W];
    end
  end

  // result transfer
  assign count_ext = {{COUNT_W{1'b0}}, count_r};
  assign out_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}}, count_ext[COUNT_W-1:0], status_r, drop_r};

endmodule

// ===== hw/rtl/ipbf_rule_table.sv =====
// rule table memory with registered read and the shared entry compare unit
module ipbf_rule_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  ipbf_pkg::rule_entry_t  wr_entry,
  input  ipbf_pkg::rule_key_t    key,
  output ipbf_pkg::scan_res_t    res,
  output logic [AW-1:0]          res_addr
);
  import ipbf_pkg::*;

  rule_entry_t       mem [DEPTH];
  rule_entry_t       rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr_r;
  logic [IP_W-1:0]   cmp_value;
  logic              kind_ok;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  // compare value follows the kind of the stored rule
  always_comb begin
    cmp_value = rd_data_r.is_port ? {{(IP_W-PORT_W){1'b0}}, key.port} : key.ip;
    kind_ok   = key.any_kind || (rd_data_r.is_port == key.is_port);
    res.hit   = rd_vld_r && rd_data_r.valid && kind_ok && (rd_data_r.value == cmp_value);
    res.free  = rd_vld_r && !rd_data_r.valid;
  end

  assign res_addr = rd_addr_r;

endmodule

// ===== dv/ip_port_ban_filter_unit_tb.sv =====
// self-checking testbench for the ip and port ban filter: directed and random commands
module ip_port_ban_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipbf_pkg::*;

  localparam int unsigned MAX_RULES = 64;
  // command codes the block does not define, answered without any change
  localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = MAX_RULES + 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // one command as it travels on the input stream
  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [IP_W-1:0]    src_ip;
    logic [PROTO_W-1:0] protocol;
    logic [PORT_W-1:0]  dst_port;
    logic [IP_W-1:0]    rule_value;
  } filter_req_t;

  // expected answer to one command
  typedef struct {
    int unsigned        seq;
    logic               drop;
    logic               status;
    logic [COUNT_W-1:0] rule_count;
  } verdict_t;

  // ban rule table copy plus the queue of answers still owed by the block
  class ban_table_sb;
    bit               used[MAX_RULES];
    bit               port_kind[MAX_RULES];
    logic [IP_W-1:0]  rule_val[MAX_RULES];
    int unsigned      n_rules;
    int unsigned      n_in;
    int unsigned      errors;
    verdict_t         pending[$];

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // lowest free slot takes the rule, duplicates allowed
    function bit add_rule(bit is_port, logic [IP_W-1:0] v);
      for (int i = 0; i < MAX_RULES; i++) begin
        if (!used[i]) begin
          used[i]      = 1'b1;
          port_kind[i] = is_port;
          rule_val[i]  = v;
          n_rules++;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // every valid entry of that kind and value goes away
    function void strike_rules(bit is_port, logic [IP_W-1:0] v);
      for (int i = 0; i < MAX_RULES; i++) begin
        if (used[i] && port_kind[i] == is_port && rule_val[i] == v) begin
          used[i] = 1'b0;
          n_rules--;
        end
      end
    endfunction

    function void note_input(filter_req_t r);
      verdict_t          v;
      logic [PORT_W-1:0] port;
      v.seq    = n_in;
      v.drop   = 1'b0;
      v.status = 1'b0;
      n_in++;
      case (r.cmd)
        CMD_CLASSIFY: begin
          // only tcp and udp carry a port, everything else looks like port 0
          port = (r.protocol == PROTO_TCP || r.protocol == PROTO_UDP) ? r.dst_port : '0;
          for (int i = 0; i < MAX_RULES; i++) begin
            if (used[i] && (port_kind[i] ? rule_val[i] == {16'h0, port}
                                         : rule_val[i] == r.src_ip))
              v.drop = 1'b1;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < MAX_RULES; i++) used[i] = 1'b0;
          n_rules = 0;
        end
        CMD_ADD_IP:   v.status = !add_rule(1'b0, r.rule_value);
        CMD_ADD_PORT: v.status = !add_rule(1'b1, {16'h0, r.rule_value[15:0]});
        CMD_DEL_IP:   strike_rules(1'b0, r.rule_value);
        CMD_DEL_PORT: strike_rules(1'b1, {16'h0, r.rule_value[15:0]});
        default: ;
      endcase
      v.rule_count = n_rules[COUNT_W-1:0];
      pending.push_back(v);
    endfunction

    task check_result(logic [OUT_DATA_W-1:0] d);
      verdict_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with no command outstanding", d));
        return;
      end
      want = pending.pop_front();
      if (d[0] !== want.drop)
        report($sformatf("cmd %0d drop %b, want %b", want.seq, d[0], want.drop));
      if (d[1] !== want.status)
        report($sformatf("cmd %0d status %b, want %b", want.seq, d[1], want.status));
      if (d[8:2] !== want.rule_count)
        report($sformatf("cmd %0d rule_count %0d, want %0d", want.seq, d[8:2],
                         want.rule_count));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  ban_table_sb sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_go        = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_cnt      = 0;

  ip_port_ban_filter_unit #(
    .MAX_RULES(MAX_RULES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[ip_port_ban_filter_unit] ERROR");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // value pools overlap between kinds so rules of one kind can shadow the other
  function automatic logic [IP_W-1:0] pick_ip();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd80;
      3: return 32'h0A00_0001;
      4: return 32'hC0A8_0001;
      5: return 32'd6;
      6: return 32'h7F00_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd80;
      3: return 16'd443;
      4: return 16'd53;
      5: return 16'd6;
      6: return 16'd17;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    case ($urandom_range(9))
      0, 1, 2, 3: return PROTO_TCP;
      4, 5, 6:    return PROTO_UDP;
      7:          return 8'd0;
      8:          return 8'hFF;
      default:    return 8'($urandom());
    endcase
  endfunction

  function automatic filter_req_t make_req(logic [CMD_W-1:0] c);
    filter_req_t r;
    r.cmd      = c;
    r.src_ip   = pick_ip();
    r.protocol = pick_proto();
    r.dst_port = pick_port();
    // port rules only keep the low half, so the upper half stays random
    if (c == CMD_ADD_PORT || c == CMD_DEL_PORT)
      r.rule_value = {16'($urandom()), pick_port()};
    else
      r.rule_value = pick_ip();
    return r;
  endfunction

  // one input transfer, with an optional idle gap ahead of it
  task automatic send_item(input filter_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, r.rule_value, r.dst_port, r.protocol,
                  r.src_ip, r.cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_input(r);
  endtask

  task automatic issue(logic [CMD_W-1:0] c, logic [IP_W-1:0] ip, logic [PROTO_W-1:0] proto,
                       logic [PORT_W-1:0] port, logic [IP_W-1:0] rv);
    filter_req_t r;
    r.cmd        = c;
    r.src_ip     = ip;
    r.protocol   = proto;
    r.dst_port   = port;
    r.rule_value = rv;
    send_item(r);
  endtask

  // random command mix weighted toward classify
  task automatic random_mix(int unsigned n);
    int unsigned      k;
    logic [CMD_W-1:0] c;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 45)      c = CMD_CLASSIFY;
      else if (k < 60) c = CMD_ADD_IP;
      else if (k < 75) c = CMD_ADD_PORT;
      else if (k < 85) c = CMD_DEL_IP;
      else if (k < 95) c = CMD_DEL_PORT;
      else if (k < 97) c = CMD_CLEAR;
      else if (k < 98) c = CMD_RSVD_A;
      else             c = CMD_RSVD_B;
      send_item(make_req(c));
    end
  endtask

  // empty the table, fill it past full with lookups in between, then prune it
  task automatic fill_burst();
    send_item(make_req(CMD_CLEAR));
    repeat (MAX_RULES + $urandom_range(2, 6)) begin
      send_item(make_req($urandom_range(1) ? CMD_ADD_PORT : CMD_ADD_IP));
      if ($urandom_range(99) < 30) send_item(make_req(CMD_CLASSIFY));
    end
    repeat (6) send_item(make_req(CMD_CLASSIFY));
    repeat (8) send_item(make_req($urandom_range(1) ? CMD_DEL_PORT : CMD_DEL_IP));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, field extremes, unknown codes
    issue(CMD_CLASSIFY, 32'h0000_0000, PROTO_TCP, 16'h0000, 32'h0000_0000);
    issue(CMD_CLASSIFY, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_RSVD_A, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue(CMD_RSVD_B, 32'h0000_0000, 8'h00, 16'h0000, 32'h0000_0000);
    // adds of both kinds at the value extremes, masked port values, duplicates
    issue(CMD_ADD_IP, 32'h0, 8'h0, 16'h0, 32'hFFFF_FFFF);
    issue(CMD_ADD_IP, 32'h0, 8'h0, 16'h0, 32'h0000_0000);
    issue(CMD_ADD_PORT, 32'h0, 8'h0, 16'h0, 32'hABCD_0050);
    issue(CMD_ADD_PORT, 32'h0, 8'h0, 16'h0, 32'hFFFF_0000);
    issue(CMD_ADD_PORT, 32'h0, 8'h0, 16'h0, 32'h0000_FFFF);
    issue(CMD_ADD_IP, 32'h0, 8'h0, 16'h0, 32'h0A00_0001);
    issue(CMD_ADD_IP, 32'h0, 8'h0, 16'h0, 32'h0A00_0001);
    issue(CMD_RSVD_A, 32'h0A00_0001, PROTO_TCP, 16'd80, 32'h0A00_0001);
    // ip hit, port hit, and a non tcp/udp packet caught by the port 0 rule
    issue(CMD_CLASSIFY, 32'h0A00_0001, PROTO_UDP, 16'd1234, 32'h0);
    issue(CMD_CLASSIFY, 32'h0102_0304, PROTO_TCP, 16'd80, 32'h0);
    issue(CMD_CLASSIFY, 32'h0102_0304, 8'd1, 16'd1234, 32'h0);
    // drop the port 0 rule: a non tcp/udp packet on port 80 now passes
    issue(CMD_DEL_PORT, 32'h0, 8'h0, 16'h0, 32'h1234_0000);
    issue(CMD_CLASSIFY, 32'h0102_0304, 8'd1, 16'd80, 32'h0);
    // an ip equal to a banned port number is not banned
    issue(CMD_CLASSIFY, 32'd80, PROTO_TCP, 16'd7, 32'h0);
    // removal takes both duplicates; removing a missing rule is harmless
    issue(CMD_DEL_IP, 32'h0, 8'h0, 16'h0, 32'h0A00_0001);
    issue(CMD_CLASSIFY, 32'h0A00_0001, PROTO_TCP, 16'd1, 32'h0);
    issue(CMD_DEL_IP, 32'h0, 8'h0, 16'h0, 32'h5555_AAAA);
    issue(CMD_CLASSIFY, 32'h1111_1111, PROTO_UDP, 16'hFFFF, 32'h0);
    issue(CMD_CLEAR, 32'h0, 8'h0, 16'h0, 32'h0);
    issue(CMD_CLASSIFY, 32'hFFFF_FFFF, PROTO_UDP, 16'hFFFF, 32'h0);

    // random: four idling patterns, each with one pass through a full table
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_go        = 1'b1;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      random_mix(85);
      fill_burst();
      random_mix(85);
    end
    in_tvalid <= 1'b0;

    // drain, then give a stray extra result time to show up
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ip_port_ban_filter_unit] OK");
    end else begin
      $display("[ip_port_ban_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
